### hw/rtl/cfsw_pkg.sv
// Package for the chunk framer: shared constants, codes and the structs that
// pass between the controller and the frame emitter.
// No dependencies.
package cfsw_pkg;

    localparam int MAX_FRAME_DEF = 128;
    localparam int OVERHEAD      = 11;
    localparam int MIN_CHUNK     = 12;
    localparam int CFG_W         = 32;
    localparam int CFG_IDX_W     = 2;

    // Register indexes of the configuration port.
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_SIZE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_FAILURES = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SYNC_WORD    = 2'd2;

    localparam logic [7:0]  FRAME_SIZE_RST   = 8'd128;
    localparam logic [7:0]  MAX_FAILURES_RST = 8'd20;
    localparam logic [31:0] SYNC_WORD_RST    = 32'h414D_4F53;

    // Input transaction kinds (carried on s_tuser).
    localparam logic [1:0] OP_BYTE    = 2'd0;
    localparam logic [1:0] OP_RESP    = 2'd1;
    localparam logic [1:0] OP_TIMEOUT = 2'd2;

    // Response byte codes.
    localparam logic [7:0] RESP_ERROR  = 8'hFF;
    localparam logic [7:0] RESP_CANCEL = 8'hAA;

    // Result status codes.
    localparam logic [2:0] ST_SENT      = 3'd0;
    localparam logic [2:0] ST_ACKED     = 3'd1;
    localparam logic [2:0] ST_DONE      = 3'd2;
    localparam logic [2:0] ST_RETRY     = 3'd3;
    localparam logic [2:0] ST_CANCELLED = 3'd4;
    localparam logic [2:0] ST_GAVE_UP   = 3'd5;
    localparam logic [2:0] ST_REFUSED   = 3'd6;

    typedef struct packed {
        logic       start;
        logic [2:0] status;
    } emit_cmd_t;

    typedef struct packed {
        logic       valid;
        logic [7:0] byte_first;
        logic [7:0] byte_second;
        logic       second_valid;
        logic       frame_last;
        logic [2:0] status;
    } emit_res_t;

endpackage

### hw/rtl/cfsw_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
// No dependencies.
module cfsw_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 117
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

### hw/rtl/cfsw_emit.sv
// Frame emitter: walks the frame one byte per cycle unless out_free holds it,
// header bytes from registers and payload bytes from the payload RAM, and pairs
// them into results. Depends on cfsw_pkg.
module cfsw_emit #(
    parameter int MAX_FRAME = cfsw_pkg::MAX_FRAME_DEF
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  cfsw_pkg::emit_cmd_t          cmd,
    input  logic [$clog2(MAX_FRAME - cfsw_pkg::OVERHEAD + 1)-1:0] fill_count,
    input  logic [31:0]                  sync_word,
    input  logic [23:0]                  chunk_index,
    input  logic [15:0]                  running_sum,
    input  logic                         out_free,
    output logic                         ram_rd_en,
    output logic [$clog2(MAX_FRAME - cfsw_pkg::OVERHEAD)-1:0] ram_rd_addr,
    input  logic [7:0]                   ram_rd_data,
    output cfsw_pkg::emit_res_t          res,
    output logic                         busy
);

    localparam int STORE_DEPTH = MAX_FRAME - cfsw_pkg::OVERHEAD;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);
    localparam int POS_W       = $clog2(MAX_FRAME + 1);
    localparam int HDR_BYTES   = 9;

    logic             active_reg;
    logic [POS_W-1:0] pos_reg;
    logic [2:0]       status_reg;
    logic             v1_reg;
    logic             sel_ram_reg;
    logic [7:0]       hdr_reg;
    logic             last1_reg;
    logic             odd1_reg;
    logic [7:0]       first_reg;

    logic [POS_W-1:0] frame_len;
    logic [POS_W-1:0] len_m1;
    logic [POS_W-1:0] len_m2;
    logic [15:0]      len16;
    logic [7:0]       hdr_byte;
    logic             is_payload;
    logic             need_out;
    logic             adv2;
    logic             issue;
    logic [7:0]       cur_byte;

    assign frame_len = POS_W'(fill_count) + POS_W'(cfsw_pkg::OVERHEAD);
    assign len_m1    = frame_len - POS_W'(1);
    assign len_m2    = frame_len - POS_W'(2);
    assign len16     = 16'(fill_count);

    // Byte selection for the position being issued.
    always_comb begin
        hdr_byte   = 8'h00;
        is_payload = 1'b0;
        if (pos_reg < POS_W'(HDR_BYTES)) begin
            case (pos_reg[3:0])
                4'd0:    hdr_byte = sync_word[31:24];
                4'd1:    hdr_byte = sync_word[23:16];
                4'd2:    hdr_byte = sync_word[15:8];
                4'd3:    hdr_byte = sync_word[7:0];
                4'd4:    hdr_byte = chunk_index[23:16];
                4'd5:    hdr_byte = chunk_index[15:8];
                4'd6:    hdr_byte = chunk_index[7:0];
                4'd7:    hdr_byte = len16[15:8];
                4'd8:    hdr_byte = len16[7:0];
                default: hdr_byte = 8'h00;
            endcase
        end else if (pos_reg == len_m2) begin
            hdr_byte = running_sum[15:8];
        end else if (pos_reg == len_m1) begin
            hdr_byte = running_sum[7:0];
        end else begin
            is_payload = 1'b1;
        end
    end

    assign need_out = odd1_reg || last1_reg;
    assign adv2     = v1_reg && (!need_out || out_free);
    assign issue    = active_reg && (!v1_reg || adv2);
    assign cur_byte = sel_ram_reg ? ram_rd_data : hdr_reg;

    assign ram_rd_en   = issue && is_payload;
    assign ram_rd_addr = ADDR_W'(pos_reg - POS_W'(HDR_BYTES));

    assign res.valid        = adv2 && need_out;
    assign res.byte_first   = odd1_reg ? first_reg : cur_byte;
    assign res.byte_second  = odd1_reg ? cur_byte : 8'h00;
    assign res.second_valid = odd1_reg;
    assign res.frame_last   = last1_reg;
    assign res.status       = status_reg;

    assign busy = active_reg || v1_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg <= 1'b0;
            v1_reg     <= 1'b0;
        end else begin
            if (cmd.start && !busy) begin
                active_reg <= 1'b1;
                pos_reg    <= '0;
                status_reg <= cmd.status;
            end else if (issue) begin
                pos_reg <= pos_reg + POS_W'(1);
                if (pos_reg == len_m1) begin
                    active_reg <= 1'b0;
                end
            end
            if (issue) begin
                v1_reg      <= 1'b1;
                sel_ram_reg <= is_payload;
                hdr_reg     <= hdr_byte;
                last1_reg   <= (pos_reg == len_m1);
                odd1_reg    <= pos_reg[0];
            end else if (adv2) begin
                v1_reg <= 1'b0;
            end
            if (adv2 && !odd1_reg) begin
                first_reg <= cur_byte;
            end
        end
    end

endmodule

### hw/rtl/chunk_framer_stop_and_wait.sv
// Top level of the stop-and-wait chunk framer: controller state, configuration
// registers, output register, payload RAM and frame emitter.
// Depends on cfsw_pkg, cfsw_ram and cfsw_emit.

// The framer collects message bytes into a payload RAM and, when the chunk is
// full (the clamped frame size register minus eleven bytes) or a byte arrives
// with s_tlast set, sends a frame: four sync bytes, a 24-bit chunk index, a
// 16-bit payload length, the payload and a 16-bit byte-sum checksum, two bytes
// per output transaction with m_tlast on the frame's final transaction. It then
// waits for a response transaction (s_tuser selects message byte, response or
// timeout). Errors, timeouts and checksum mismatches resend the frame until
// max_failures is reached, a cancel or a give-up ends the run, and a good
// acknowledgement moves to the next chunk or, after the final one, ends the run.
// Every other outcome is reported by one status-only transaction with m_tlast
// set. Timing: between frames, a status-only item is accepted when the output
// register is free or being drained, and its result appears in the next cycle.
// A frame with n payload bytes has n + 11 bytes, sent as ceil((n + 11) / 2)
// output transactions; it leaves at one byte per cycle, set by the single read
// port of the payload RAM, while m_tready does not hold the output register;
// s_tready stays low while a frame is going out. The payload RAM needs no
// clearing after reset, since a frame only reads bytes written for its chunk.
module chunk_framer_stop_and_wait #(
    parameter int MAX_FRAME = cfsw_pkg::MAX_FRAME_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    // Input stream
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // [7:0] data_byte, [15:8] resp_first, [23:16] resp_second,
    // [31:24] resp_sum_high, [39:32] resp_sum_low
    input  logic [39:0]                    s_tdata,
    // [1:0] op
    input  logic [1:0]                     s_tuser,
    input  logic                           s_tlast,
    // Result stream
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // [0] carries_bytes, [8:1] byte_first, [16:9] byte_second,
    // [17] second_valid, [20:18] status, [23:21] zero
    output logic [23:0]                    m_tdata,
    output logic                           m_tlast,
    // Configuration write port
    input  logic                           cfg_wr_en,
    input  logic [cfsw_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [cfsw_pkg::CFG_W-1:0]     cfg_data
);

    localparam int STORE_DEPTH = MAX_FRAME - cfsw_pkg::OVERHEAD;
    localparam int FILL_W      = $clog2(STORE_DEPTH + 1);
    localparam int ADDR_W      = $clog2(STORE_DEPTH);

    // Configuration registers
    logic [7:0]  frame_size_reg;
    logic [7:0]  max_failures_reg;
    logic [31:0] sync_word_reg;

    // Run state
    logic [FILL_W-1:0] fill_reg,     fill_next;
    logic [23:0]       index_reg,    index_next;
    logic [7:0]        fail_reg,     fail_next;
    logic [15:0]       sum_reg,      sum_next;
    logic              awaiting_reg, awaiting_next;
    logic              final_reg,    final_next;

    // Output register
    logic        out_valid_reg;
    logic        out_carries_reg;
    logic [7:0]  out_first_reg;
    logic [7:0]  out_second_reg;
    logic        out_second_valid_reg;
    logic        out_last_reg;
    logic [2:0]  out_status_reg;

    // Input fields
    logic [1:0] op;
    logic [7:0] data_byte;
    logic [7:0] resp_first;
    logic [7:0] resp_second;
    logic [7:0] resp_sum_high;
    logic [7:0] resp_sum_low;

    logic                in_acc;
    logic                out_free;
    logic                emit_busy;
    cfsw_pkg::emit_cmd_t cmd;
    cfsw_pkg::emit_res_t res;
    logic                st_load;
    logic [2:0]          st_code;
    logic                ram_wr_en;
    logic                ram_rd_en;
    logic [ADDR_W-1:0]   ram_rd_addr;
    logic [7:0]          ram_rd_data;

    logic [7:0]        cs_clamped;
    logic [7:0]        capacity;
    logic [FILL_W-1:0] fill_inc;
    logic [7:0]        fail_inc;
    logic              resp_error;
    logic              resp_cancel;
    logic              sum_mismatch;
    logic              failed;

    assign op            = s_tuser;
    assign data_byte     = s_tdata[7:0];
    assign resp_first    = s_tdata[15:8];
    assign resp_second   = s_tdata[23:16];
    assign resp_sum_high = s_tdata[31:24];
    assign resp_sum_low  = s_tdata[39:32];

    assign out_free = !out_valid_reg || m_tready;
    assign s_tready = !emit_busy && out_free;
    assign in_acc   = s_tvalid && s_tready;

    // Effective payload capacity from the clamped frame size.
    always_comb begin
        cs_clamped = frame_size_reg;
        if (cs_clamped < 8'(cfsw_pkg::MIN_CHUNK)) begin
            cs_clamped = 8'(cfsw_pkg::MIN_CHUNK);
        end
        if (cs_clamped > 8'(MAX_FRAME)) begin
            cs_clamped = 8'(MAX_FRAME);
        end
    end
    assign capacity = cs_clamped - 8'(cfsw_pkg::OVERHEAD);
    assign fill_inc = fill_reg + FILL_W'(1);
    assign fail_inc = (fail_reg != 8'hFF) ? fail_reg + 8'd1 : fail_reg;

    // Response classification, error taking priority over cancel.
    assign resp_error   = (op == cfsw_pkg::OP_TIMEOUT) ||
                          (resp_first == cfsw_pkg::RESP_ERROR) ||
                          (resp_second == cfsw_pkg::RESP_ERROR);
    assign resp_cancel  = (resp_first == cfsw_pkg::RESP_CANCEL) ||
                          (resp_second == cfsw_pkg::RESP_CANCEL);
    assign sum_mismatch = (resp_sum_high != sum_reg[15:8]) ||
                          (resp_sum_low != sum_reg[7:0]);
    assign failed       = resp_error || (!resp_cancel && sum_mismatch);

    always_comb begin
        fill_next     = fill_reg;
        index_next    = index_reg;
        fail_next     = fail_reg;
        sum_next      = sum_reg;
        awaiting_next = awaiting_reg;
        final_next    = final_reg;
        st_load       = 1'b0;
        st_code       = cfsw_pkg::ST_REFUSED;
        cmd.start     = 1'b0;
        cmd.status    = cfsw_pkg::ST_SENT;
        ram_wr_en     = 1'b0;
        if (in_acc) begin
            case (op)
                cfsw_pkg::OP_BYTE: begin
                    if (awaiting_reg || (fill_reg >= FILL_W'(STORE_DEPTH))) begin
                        st_load = 1'b1;
                    end else begin
                        ram_wr_en = 1'b1;
                        sum_next  = sum_reg + 16'(data_byte);
                        fill_next = fill_inc;
                        if (s_tlast || (8'(fill_inc) >= capacity)) begin
                            awaiting_next = 1'b1;
                            final_next    = s_tlast;
                            cmd.start     = 1'b1;
                            cmd.status    = cfsw_pkg::ST_SENT;
                        end
                    end
                end
                cfsw_pkg::OP_RESP, cfsw_pkg::OP_TIMEOUT: begin
                    if (!awaiting_reg) begin
                        st_load = 1'b1;
                    end else if (failed) begin
                        fail_next = fail_inc;
                        if (fail_inc >= max_failures_reg) begin
                            st_load       = 1'b1;
                            st_code       = cfsw_pkg::ST_GAVE_UP;
                            fill_next     = '0;
                            index_next    = '0;
                            fail_next     = '0;
                            sum_next      = '0;
                            awaiting_next = 1'b0;
                            final_next    = 1'b0;
                        end else begin
                            cmd.start  = 1'b1;
                            cmd.status = cfsw_pkg::ST_RETRY;
                        end
                    end else begin
                        // Cancel or acknowledgement: both leave the chunk empty.
                        st_load       = 1'b1;
                        fill_next     = '0;
                        fail_next     = '0;
                        sum_next      = '0;
                        awaiting_next = 1'b0;
                        if (resp_cancel || final_reg) begin
                            st_code    = resp_cancel ? cfsw_pkg::ST_CANCELLED
                                                     : cfsw_pkg::ST_DONE;
                            index_next = '0;
                            final_next = 1'b0;
                        end else begin
                            st_code    = cfsw_pkg::ST_ACKED;
                            index_next = index_reg + 24'd1;
                        end
                    end
                end
                default: begin
                    st_load = 1'b1;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frame_size_reg   <= cfsw_pkg::FRAME_SIZE_RST;
            max_failures_reg <= cfsw_pkg::MAX_FAILURES_RST;
            sync_word_reg    <= cfsw_pkg::SYNC_WORD_RST;
            fill_reg         <= '0;
            index_reg        <= '0;
            fail_reg         <= '0;
            sum_reg          <= '0;
            awaiting_reg     <= 1'b0;
            final_reg        <= 1'b0;
            out_valid_reg    <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                case (cfg_index)
                    cfsw_pkg::REG_FRAME_SIZE:   frame_size_reg   <= cfg_data[7:0];
                    cfsw_pkg::REG_MAX_FAILURES: max_failures_reg <= cfg_data[7:0];
                    cfsw_pkg::REG_SYNC_WORD:    sync_word_reg    <= cfg_data[31:0];
                    default: ;
                endcase
            end
            fill_reg     <= fill_next;
            index_reg    <= index_next;
            fail_reg     <= fail_next;
            sum_reg      <= sum_next;
            awaiting_reg <= awaiting_next;
            final_reg    <= final_next;
            if (res.valid || st_load) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Output payload; the emitter and the status path never load together,
    // since no input transaction is taken while a frame is going out.
    always_ff @(posedge aclk) begin
        if (res.valid) begin
            out_carries_reg      <= 1'b1;
            out_first_reg        <= res.byte_first;
            out_second_reg       <= res.byte_second;
            out_second_valid_reg <= res.second_valid;
            out_last_reg         <= res.frame_last;
            out_status_reg       <= res.status;
        end else if (st_load) begin
            out_carries_reg      <= 1'b0;
            out_first_reg        <= 8'h00;
            out_second_reg       <= 8'h00;
            out_second_valid_reg <= 1'b0;
            out_last_reg         <= 1'b1;
            out_status_reg       <= st_code;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tlast  = out_last_reg;
    assign m_tdata  = {3'b000, out_status_reg, out_second_valid_reg,
                       out_second_reg, out_first_reg, out_carries_reg};

    cfsw_ram #(
        .WIDTH (8),
        .DEPTH (STORE_DEPTH)
    ) u_payload_ram (
        .aclk    (aclk),
        .wr_en   (ram_wr_en),
        .wr_addr (fill_reg[ADDR_W-1:0]),
        .wr_data (data_byte),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    cfsw_emit #(
        .MAX_FRAME (MAX_FRAME)
    ) u_emit (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd         (cmd),
        .fill_count  (fill_reg),
        .sync_word   (sync_word_reg),
        .chunk_index (index_reg),
        .running_sum (sum_reg),
        .out_free    (out_free),
        .ram_rd_en   (ram_rd_en),
        .ram_rd_addr (ram_rd_addr),
        .ram_rd_data (ram_rd_data),
        .res         (res),
        .busy        (emit_busy)
    );

    // A frame is only ever on its way out while a response is awaited.
    assert property (@(posedge aclk) disable iff (!aresetn)
        emit_busy |-> awaiting_reg)
        else $error("frame emission without a pending response");

    // The fill count never runs past the payload RAM.
    assert property (@(posedge aclk) disable iff (!aresetn)
        fill_reg <= FILL_W'(STORE_DEPTH))
        else $error("fill count beyond payload RAM depth");

    // The emitter never overwrites a result that is still waiting.
    assert property (@(posedge aclk) disable iff (!aresetn)
        res.valid |-> (out_free && !st_load))
        else $error("emitter result collides with the output register");

    // Starting a frame always makes the emitter busy in the next cycle.
    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.start |=> emit_busy)
        else $error("frame start lost");

endmodule
